FILE: rtl/bmca_pkg.sv
// Package for the BRDF Monte Carlo accumulator: payload types, fixed-point
// constants and the arctangent table of the rotation unit.
// No dependencies.
package bmca_pkg;

  localparam int unsigned CountBitsDef = 20;
  localparam int unsigned FracBitsDef  = 14;
  localparam int unsigned TrigIterDef  = 16;

  localparam int unsigned ExpWidth = 7;
  localparam logic [ExpWidth-1:0] ExpReset = 7'd10;

  // Internal signed Q30 values; products are 72 bits wide before the shift.
  localparam int unsigned QW = 36;
  localparam logic signed [QW-1:0] Q30One    = 36'sd1073741824;
  localparam logic signed [QW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [QW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [QW-1:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [QW-1:0] GainQ30   = 36'sd652032874;
  localparam logic [35:0] Pi2Q30 = 36'd10597407032;
  localparam logic [39:0] SumMax = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [14:0] incoming_zenith;
    logic [16:0] incoming_azimuth;
    logic [14:0] reflected_zenith;
    logic [16:0] reflected_azimuth;
    logic        last_sample;
  } sample_t;

  typedef struct packed {
    logic [15:0] mean_value;
    logic [15:0] integral_estimate;
    logic [15:0] best_estimate;
    logic [14:0] best_zenith;
    logic [16:0] best_azimuth;
    logic        new_best;
  } result_t;

  // Arctangent of 2^-i in Q30.
  function automatic logic signed [QW-1:0] atan_q30(input logic [4:0] i);
    logic signed [QW-1:0] r;
    unique case (i)
      5'd0: r = 36'sd843314857;
      5'd1: r = 36'sd497837829;
      5'd2: r = 36'sd263043837;
      5'd3: r = 36'sd133525159;
      5'd4: r = 36'sd67021687;
      5'd5: r = 36'sd33543516;
      5'd6: r = 36'sd16775851;
      5'd7: r = 36'sd8388437;
      5'd8: r = 36'sd4194283;
      5'd9: r = 36'sd2097149;
      5'd31: r = '0;
      default: r = QW'(36'sd1048576 >>> (i - 5'd10));
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/brdf_monte_carlo_accumulator_top.sv
// From an accepted last sample to its result the sequencer runs the four rotation
// passes, the dot product, 32 square-root and 30 quotient steps, the power loop and
// a 40-step mean. A new sample is taken only while the sequencer is idle and no
// result waits; an angle of 2pi or above is first reduced by a subtraction, and a
// non-positive 1 + dot product skips the root, quotient and power steps.
// Reset (asynchronous, active low) clears sums, counts, running maximum and sets
// the exponent to 10.
// Top level: one sequencer over a shared unit. Depends on bmca_pkg.
module brdf_monte_carlo_accumulator_top #(
  parameter int unsigned COUNT_BITS      = bmca_pkg::CountBitsDef,
  parameter int unsigned FRAC_BITS       = bmca_pkg::FracBitsDef,
  parameter int unsigned TRIG_ITERATIONS = bmca_pkg::TrigIterDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bmca_pkg::sample_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bmca_pkg::result_t out_data_o
);
  import bmca_pkg::*;

  localparam int unsigned SH = 30 - FRAC_BITS;
  localparam logic [35:0] Pi2Q = 36'((Pi2Q30 + (36'd1 << (SH - 1))) >> SH);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_ANG, S_RED, S_CORD, S_FLIP, S_DOT, S_DSUM, S_SQRT, S_DIV,
    S_POW, S_T1, S_T2, S_ACC, S_MEAN, S_INT, S_OUT
  } state_e;

  state_e state_q;
  sample_t smp_q;
  logic [ExpWidth-1:0] exp_q;
  logic [39:0] sum_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [15:0] max_est_q;
  logic [14:0] max_zen_q;
  logic [16:0] max_azi_q;
  result_t res_q;
  logic out_valid_q;

  // Working registers.
  logic [1:0] ang_q;              // which angle is in the rotation unit
  logic signed [QW-1:0] x_q, y_q, z_q;
  logic flip_q;
  logic [5:0] it_q;               // shared step counter
  logic signed [QW-1:0] sn_q [4];
  logic signed [QW-1:0] cs_q [4];
  logic signed [QW-1:0] acc_q, dot_q;
  logic [63:0] rem_q, res64_q, bit_q;
  logic [65:0] div_q;             // remainder and quotient shifting
  logic [35:0] root_q;
  logic signed [QW-1:0] h_q, p_q;
  logic [6:0] pcnt_q;

  // Shared multiplier: Q30 by Q30 with floor shift.
  logic signed [QW-1:0] ma, mb, mres;
  logic signed [2*QW-1:0] mprod;
  assign mprod = ma * mb;
  assign mres = QW'(mprod >>> 30);

  // Angle selection and scaling into Q30.
  logic [16:0] ang_sel;
  logic [35:0] ang_q30;
  always_comb begin
    unique case (ang_q)
      2'd0: ang_sel = {2'b0, smp_q.incoming_zenith};
      2'd1: ang_sel = smp_q.incoming_azimuth;
      2'd2: ang_sel = {2'b0, smp_q.reflected_zenith};
      default: ang_sel = smp_q.reflected_azimuth;
    endcase
  end
  assign ang_q30 = 36'(ang_sel) << SH;

  // Multiplier operand selection per step.
  always_comb begin
    ma = p_q;
    mb = h_q;
    unique case (state_q)
      S_DOT: begin
        unique case (it_q[2:0])
          3'd0: begin ma = sn_q[0]; mb = cs_q[1]; end
          3'd1: begin ma = acc_q;   mb = sn_q[2]; end
          3'd2: begin ma = acc_q;   mb = cs_q[3]; end
          3'd3: begin ma = cs_q[0]; mb = cs_q[2]; end
          3'd4: begin ma = sn_q[0]; mb = sn_q[1]; end
          3'd5: begin ma = acc_q;   mb = sn_q[2]; end
          default: begin ma = acc_q; mb = sn_q[3]; end
        endcase
      end
      S_T1: begin ma = p_q;   mb = cs_q[2]; end
      S_T2: begin ma = acc_q; mb = sn_q[2]; end
      default: ;
    endcase
  end

  logic signed [QW-1:0] dx, dy, at;
  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign at = atan_q30(it_q[4:0]);

  logic [63:0] sq_try;
  assign sq_try = res64_q + bit_q;
  logic [65:0] div_sh;
  assign div_sh = {div_q[64:0], 1'b0};

  // Partial remainder of the mean division with the next sum bit shifted in.
  logic [63:0] mrem_sh;
  assign mrem_sh = {rem_q[62:0], div_q[39]};

  logic signed [QW-1:0] num;
  assign num = cs_q[0] + cs_q[2];
  logic [35:0] mag;
  assign mag = num[QW-1] ? 36'(-num) : 36'(num);

  // Sum of the running total and the new term, with a carry bit for saturation.
  logic [40:0] sum_add;
  assign sum_add = 41'(sum_q) + 41'(acc_q);

  // Integral estimate; the overflow flag of the mean rides in new_best.
  logic [15:0] integ_w;
  logic [51:0] integ_p;
  assign integ_p = 52'(res_q.mean_value) * 52'(Pi2Q[35:0]);
  assign integ_w = res_q.new_best ? 16'hFFFF :
                   ((integ_p >> FRAC_BITS) > 52'hFFFF ? 16'hFFFF :
                    16'(integ_p >> FRAC_BITS));

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      exp_q <= ExpReset;
      sum_q <= '0;
      cnt_q <= '0;
      max_est_q <= '0;
      max_zen_q <= '0;
      max_azi_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        exp_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            smp_q <= in_data_i;
            ang_q <= 2'd0;
            state_q <= S_ANG;
          end
        end
        // Reduce modulo 2pi, then fold into +-pi/2 with a sign flip; a 17-bit angle needs at most one subtraction.
        S_ANG: begin
          z_q <= $signed(ang_q30);
          state_q <= S_RED;
        end
        S_RED: begin
          if (z_q >= TwoPiQ30) begin
            z_q <= z_q - TwoPiQ30;
          end else begin
            x_q <= GainQ30;
            y_q <= '0;
            it_q <= '0;
            priority if (z_q > PiQ30 && (z_q - TwoPiQ30) < -HalfPiQ30) begin
              z_q <= z_q - TwoPiQ30 + PiQ30;
              flip_q <= 1'b1;
            end else if (z_q > PiQ30) begin
              z_q <= z_q - TwoPiQ30;
              flip_q <= 1'b0;
            end else if (z_q > HalfPiQ30) begin
              z_q <= z_q - PiQ30;
              flip_q <= 1'b1;
            end else begin
              flip_q <= 1'b0;
            end
            state_q <= S_CORD;
          end
        end
        // One rotation step per cycle.
        S_CORD: begin
          if (it_q == 6'(TRIG_ITERATIONS)) begin
            state_q <= S_FLIP;
          end else begin
            if (!z_q[QW-1]) begin
              x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
            end else begin
              x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
            end
            it_q <= it_q + 6'd1;
          end
        end
        S_FLIP: begin
          sn_q[ang_q] <= flip_q ? -y_q : y_q;
          cs_q[ang_q] <= flip_q ? -x_q : x_q;
          if (ang_q == 2'd3) begin
            it_q <= '0;
            dot_q <= '0;
            state_q <= S_DOT;
          end else begin
            ang_q <= ang_q + 2'd1;
            state_q <= S_ANG;
          end
        end
        // Dot product through the shared multiplier.
        S_DOT: begin
          acc_q <= mres;
          it_q <= it_q + 6'd1;
          if (it_q == 6'd2 || it_q == 6'd3) dot_q <= dot_q + mres;
          if (it_q == 6'd6) begin
            dot_q <= dot_q + mres;
            state_q <= S_DSUM;
          end
        end
        S_DSUM: begin
          if ((Q30One + dot_q) <= 0) begin
            acc_q <= '0;
            state_q <= S_ACC;
          end else begin
            rem_q <= (((Q30One + dot_q) > (Q30One <<< 1)) ?
                       64'(Q30One <<< 2) : 64'((Q30One + dot_q) <<< 1)) << 30;
            res64_q <= '0;
            bit_q <= 64'd1 << 62;
            it_q <= '0;
            state_q <= S_SQRT;
          end
        end
        // Square root, one result bit per cycle.
        S_SQRT: begin
          if (it_q == 6'd32) begin
            root_q <= 36'(res64_q);
            div_q <= {mag, 30'd0};
            it_q <= '0;
            state_q <= S_DIV;
          end else begin
            if (rem_q >= sq_try) begin
              rem_q <= rem_q - sq_try;
              res64_q <= (res64_q >> 1) + bit_q;
            end else begin
              res64_q <= res64_q >> 1;
            end
            bit_q <= bit_q >> 2;
            it_q <= it_q + 6'd1;
          end
        end
        // Restoring division of mag << 30 by root, one bit per cycle. When mag
        // reaches root the quotient is at least one and h clamps to one.
        S_DIV: begin
          if (it_q == 6'd30) begin
            h_q <= (mag >= root_q) ?
                   (num[QW-1] ? -Q30One : Q30One) :
                   (num[QW-1] ? -$signed({6'd0, div_q[29:0]}) :
                                $signed({6'd0, div_q[29:0]}));
            p_q <= Q30One;
            pcnt_q <= '0;
            state_q <= S_POW;
          end else begin
            if (div_sh[65:30] >= root_q) begin
              div_q <= {div_sh[65:30] - root_q, div_sh[29:1], 1'b1};
            end else begin
              div_q <= div_sh;
            end
            it_q <= it_q + 6'd1;
          end
        end
        S_POW: begin
          if (pcnt_q == exp_q) begin
            state_q <= S_T1;
          end else begin
            p_q <= mres;
            pcnt_q <= pcnt_q + 7'd1;
          end
        end
        S_T1: begin
          acc_q <= mres;
          state_q <= S_T2;
        end
        S_T2: begin
          acc_q <= (mres <= 0) ? '0 : mres >>> SH;
          state_q <= S_ACC;
        end
        // Accumulate and count.
        S_ACC: begin
          sum_q <= sum_add[40] ? SumMax : sum_add[39:0];
          if (cnt_q != CountMax) cnt_q <= cnt_q + 1'b1;
          if (smp_q.last_sample) begin
            div_q <= {26'd0, sum_add[40] ? SumMax : sum_add[39:0]};
            rem_q <= '0;
            it_q <= '0;
            state_q <= S_MEAN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        // Mean: sum / count, one bit per cycle over 40 bits.
        S_MEAN: begin
          if (it_q == 6'd40) begin
            res_q.mean_value <= (div_q[39:16] != '0) ? 16'hFFFF : div_q[15:0];
            res_q.new_best <= (div_q[39:16] != '0);
            state_q <= S_INT;
          end else begin
            if (mrem_sh >= 64'(cnt_q)) begin
              rem_q <= mrem_sh - 64'(cnt_q);
              div_q <= {div_q[64:0], 1'b1};
            end else begin
              rem_q <= mrem_sh;
              div_q <= {div_q[64:0], 1'b0};
            end
            it_q <= it_q + 6'd1;
          end
        end
        S_INT: begin
          res_q.integral_estimate <= integ_w;
          if (integ_w > max_est_q) begin
            max_est_q <= integ_w;
            max_zen_q <= smp_q.incoming_zenith;
            max_azi_q <= smp_q.incoming_azimuth;
            res_q.new_best <= 1'b1;
          end else begin
            res_q.new_best <= 1'b0;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          res_q.best_estimate <= max_est_q;
          res_q.best_zenith <= max_zen_q;
          res_q.best_azimuth <= max_azi_q;
          sum_q <= '0;
          cnt_q <= '0;
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // No new transaction while a result waits.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_o) else $error("accept while result pending");
  // A result appears only from the final step.
  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT) else $error("stray result");
  // Count is cleared after a result.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> cnt_q == '0) else $error("count not cleared");
`endif

endmodule
